@@ hw/rtl/blake2b_nonce_target_check_assert.svh @@
// Assertion macros for the nonce check RTL.
`ifndef BLAKE2B_NONCE_TARGET_CHECK_ASSERT_SVH
`define BLAKE2B_NONCE_TARGET_CHECK_ASSERT_SVH
// Implication checked on every rising edge, disabled in reset.
`define B2N_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define B2N_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

@@ hw/rtl/b2nc_pkg.sv @@
// ----------------------------------------------------------------------------
// b2nc_pkg
// Shared constants, types and functions of the BLAKE2b nonce target check.
// ----------------------------------------------------------------------------
package b2nc_pkg;

   localparam int HeaderWords = 10;
   localparam int Rounds      = 12;
   localparam int Stages      = Rounds * 4;   // one half G mix per stage
   localparam int NonceWord   = 4;

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_CHECK = 1'b1;

   localparam logic [0:0] CSR_TARGET_SHIFT = 1'b0;

   localparam logic [63:0] PARAM_WORD = 64'h0000000001010020;

   typedef logic [63:0] word_type;
   typedef word_type [15:0] state_type;
   typedef word_type [15:0] msg_type;
   typedef logic [3:0] sel_type;

   localparam word_type [7:0] IV = '{
      64'h5be0cd19137e2179, 64'h1f83d9abfb41bd6b,
      64'h9b05688c2b3e6c1f, 64'h510e527fade682d1,
      64'ha54ff53a5f1d36f1, 64'h3c6ef372fe94f82b,
      64'hbb67ae8584caa73b, 64'h6a09e667f3bcc908};

   // message schedule, index [round%10][slot]
   localparam logic [9:0][15:0][3:0] SIGMA = '{
      '{4'd0,4'd13,4'd12,4'd3,4'd14,4'd9,4'd11,4'd15,4'd5,4'd1,4'd6,4'd7,4'd4,4'd8,4'd2,4'd10},
      '{4'd5,4'd10,4'd4,4'd1,4'd7,4'd13,4'd2,4'd12,4'd8,4'd0,4'd3,4'd11,4'd9,4'd14,4'd15,4'd6},
      '{4'd10,4'd2,4'd6,4'd8,4'd4,4'd15,4'd0,4'd5,4'd9,4'd3,4'd1,4'd12,4'd14,4'd7,4'd11,4'd13},
      '{4'd11,4'd8,4'd2,4'd9,4'd3,4'd6,4'd7,4'd0,4'd10,4'd4,4'd13,4'd14,4'd15,4'd1,4'd5,4'd12},
      '{4'd9,4'd1,4'd14,4'd15,4'd5,4'd7,4'd13,4'd4,4'd3,4'd8,4'd11,4'd0,4'd10,4'd6,4'd12,4'd2},
      '{4'd13,4'd3,4'd8,4'd6,4'd12,4'd11,4'd1,4'd14,4'd15,4'd10,4'd4,4'd2,4'd7,4'd5,4'd0,4'd9},
      '{4'd8,4'd15,4'd0,4'd4,4'd10,4'd5,4'd6,4'd2,4'd14,4'd11,4'd12,4'd13,4'd1,4'd3,4'd9,4'd7},
      '{4'd4,4'd9,4'd1,4'd7,4'd6,4'd3,4'd14,4'd10,4'd13,4'd15,4'd2,4'd5,4'd0,4'd12,4'd8,4'd11},
      '{4'd3,4'd5,4'd7,4'd11,4'd2,4'd0,4'd12,4'd1,4'd6,4'd13,4'd15,4'd9,4'd8,4'd4,4'd10,4'd14},
      '{4'd15,4'd14,4'd13,4'd12,4'd11,4'd10,4'd9,4'd8,4'd7,4'd6,4'd5,4'd4,4'd3,4'd2,4'd1,4'd0}};

   function automatic word_type rotr(word_type x, int n);
      return (x >> n) | (x << (64 - n));
   endfunction

   // first half of G rotates by 32 and 24, second half by 16 and 63
   function automatic logic [255:0] g_half(word_type a, word_type b, word_type c,
                                           word_type d, word_type x, logic second);
      word_type a1, b1, c1, d1;
      a1 = a + b + x;
      d1 = second ? rotr(d ^ a1, 16) : rotr(d ^ a1, 32);
      c1 = c + d1;
      b1 = second ? rotr(b ^ c1, 63) : rotr(b ^ c1, 24);
      return {a1, b1, c1, d1};
   endfunction

   function automatic word_type bswap(word_type x);
      word_type r;
      for (int i = 0; i < 8; i++) begin
         r[8*i +: 8] = x[8*(7-i) +: 8];
      end
      return r;
   endfunction

endpackage

@@ hw/rtl/b2nc_round.sv @@
// ----------------------------------------------------------------------------
// b2nc_round
// One registered half G mix across the four columns or the four diagonals.
// ----------------------------------------------------------------------------
module b2nc_round (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic [5:0]         stage_num,
   input  logic               valid_in,
   input  b2nc_pkg::state_type v_in,
   input  b2nc_pkg::msg_type   m_in,
   input  logic [31:0]        nonce_in,
   output logic               valid_out,
   output b2nc_pkg::state_type v_out,
   output b2nc_pkg::msg_type   m_out,
   output logic [31:0]        nonce_out
);

   logic               valid_ff;
   b2nc_pkg::state_type v_ff, v_in_c;
   b2nc_pkg::msg_type   m_ff;
   logic [31:0]        nonce_ff;
   logic [3:0]         rnd;
   logic               diag;
   logic               second;
   logic [255:0]       g [4];

   // rounds ten and eleven reuse schedule rows zero and one
   assign rnd    = (stage_num[5:2] >= 4'd10) ? stage_num[5:2] - 4'd10 : stage_num[5:2];
   assign diag   = stage_num[1];
   assign second = stage_num[0];

   always_comb begin
      v_in_c = v_in;
      for (int k = 0; k < 4; k++) begin
         int ia, ib, ic, id, s;
         ia = k;
         ib = diag ? 4 + ((k + 1) % 4) : 4 + k;
         ic = diag ? 8 + ((k + 2) % 4) : 8 + k;
         id = diag ? 12 + ((k + 3) % 4) : 12 + k;
         s  = (diag ? 8 + 2*k : 2*k) + (second ? 1 : 0);
         g[k] = b2nc_pkg::g_half(v_in[ia], v_in[ib], v_in[ic], v_in[id],
                                 m_in[b2nc_pkg::SIGMA[rnd][s]], second);
         v_in_c[ia] = g[k][255:192];
         v_in_c[ib] = g[k][191:128];
         v_in_c[ic] = g[k][127:64];
         v_in_c[id] = g[k][63:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
      if (advance) begin
         v_ff     <= v_in_c;
         m_ff     <= m_in;
         nonce_ff <= nonce_in;
      end
   end

   assign valid_out = valid_ff;
   assign v_out     = v_ff;
   assign m_out     = m_ff;
   assign nonce_out = nonce_ff;

endmodule

@@ hw/rtl/b2nc_compare.sv @@
// ----------------------------------------------------------------------------
// b2nc_compare
// Finalise digest and compare it, big-endian, with the shifted target.
// ----------------------------------------------------------------------------
module b2nc_compare (
   input  b2nc_pkg::state_type v,
   input  logic [7:0]         target_shift,
   output b2nc_pkg::word_type [3:0] digest,
   output logic               meets
);

   logic [255:0] dg_be, tgt;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         b2nc_pkg::word_type ivw;
         ivw = b2nc_pkg::IV[i];
         if (i == 0) ivw = ivw ^ b2nc_pkg::PARAM_WORD;
         digest[i] = ivw ^ v[i] ^ v[8+i];
         dg_be[255 - 64*i -: 64] = b2nc_pkg::bswap(digest[i]);
      end
      tgt   = {32'h0, {224{1'b1}}} >> target_shift;
      meets = dg_be <= tgt;
   end

endmodule

@@ hw/rtl/blake2b_nonce_target_check.sv @@
// ----------------------------------------------------------------------------
// blake2b_nonce_target_check
// Pipelined BLAKE2b-256 nonce hash with difficulty target compare.
// ----------------------------------------------------------------------------
// One check transfer per clock while the output is not stalled: each nonce
// runs through 48 stages, four for each of the 12 rounds (first and second
// half of the column mixes, then of the diagonal mixes), then a final stage
// that forms the digest and compares it with the target. Load transfers
// write the header register file and cause no result. Downstream stalls
// freeze the whole pipe; the output register is the last stage, so a new
// request is taken whenever that stage is empty or being drained.
module blake2b_nonce_target_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [3:0]  req_word_index,
   input  logic [63:0] req_word_value,
   input  logic [31:0] req_nonce,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_meets_target,
   output logic [31:0] rsp_nonce_echo,
   output logic [63:0] rsp_digest_word0,
   output logic [63:0] rsp_digest_word1,
   output logic [63:0] rsp_digest_word2,
   output logic [63:0] rsp_digest_word3,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   `include "blake2b_nonce_target_check_assert.svh"

   localparam int S = b2nc_pkg::Stages;

   logic [7:0]  target_shift_ff;
   b2nc_pkg::word_type [b2nc_pkg::HeaderWords-1:0] header_ff;
   logic        advance, out_valid_ff;
   logic        accept;

   logic                valid_s [S+1];
   b2nc_pkg::state_type v_s     [S+1];
   b2nc_pkg::msg_type   m_s     [S+1];
   logic [31:0]         nonce_s [S+1];

   b2nc_pkg::word_type [3:0] digest_c;
   logic                     meets_c;
   b2nc_pkg::word_type [3:0] digest_ff;
   logic                     meets_ff;
   logic [31:0]              nonce_ff;

   // Hold the whole pipe while a result waits.
   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign accept    = req_valid && req_ready;

   // Configuration: single register at index zero.
   assign pready = 1'b1;
   always_comb begin
      prdata = '0;
      if (paddr[2] == b2nc_pkg::CSR_TARGET_SHIFT) prdata = {24'h0, target_shift_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_shift_ff <= '0;
      end else if (psel && penable && pwrite && paddr[2] == b2nc_pkg::CSR_TARGET_SHIFT) begin
         target_shift_ff <= pwdata[7:0];
      end
   end

   // Header register file; drop out-of-range loads.
   always_ff @(posedge clock) begin
      if (accept && req_func == b2nc_pkg::FUNC_LOAD &&
          req_word_index < 4'(b2nc_pkg::HeaderWords)) begin
         header_ff[req_word_index] <= req_word_value;
      end
   end

   // Stage zero inputs: message block and initial working vector.
   always_comb begin
      m_s[0] = '0;
      for (int i = 0; i < b2nc_pkg::HeaderWords; i++) m_s[0][i] = header_ff[i];
      m_s[0][b2nc_pkg::NonceWord][31:0] = req_nonce;
      for (int i = 0; i < 8; i++) begin
         v_s[0][i]   = b2nc_pkg::IV[i];
         v_s[0][8+i] = b2nc_pkg::IV[i];
      end
      v_s[0][0]  = v_s[0][0] ^ b2nc_pkg::PARAM_WORD;
      v_s[0][12] = v_s[0][12] ^ 64'(b2nc_pkg::HeaderWords * 8);
      v_s[0][14] = ~v_s[0][14];
      valid_s[0] = req_valid && req_func == b2nc_pkg::FUNC_CHECK;
      nonce_s[0] = req_nonce;
   end

   for (genvar g = 0; g < S; g++) begin : g_stage
      b2nc_round u_round (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .stage_num (6'(g)),
         .valid_in  (valid_s[g]),
         .v_in      (v_s[g]),
         .m_in      (m_s[g]),
         .nonce_in  (nonce_s[g]),
         .valid_out (valid_s[g+1]),
         .v_out     (v_s[g+1]),
         .m_out     (m_s[g+1]),
         .nonce_out (nonce_s[g+1])
      );
   end

   b2nc_compare u_compare (
      .v            (v_s[S]),
      .target_shift (target_shift_ff),
      .digest       (digest_c),
      .meets        (meets_c)
   );

   // Output register: advance with the pipe.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= valid_s[S];
      end
      if (advance) begin
         digest_ff <= digest_c;
         meets_ff  <= meets_c;
         nonce_ff  <= nonce_s[S];
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_meets_target = meets_ff;
   assign rsp_nonce_echo   = nonce_ff;
   assign rsp_digest_word0 = digest_ff[0];
   assign rsp_digest_word1 = digest_ff[1];
   assign rsp_digest_word2 = digest_ff[2];
   assign rsp_digest_word3 = digest_ff[3];

   `B2N_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_nonce_echo), "stalled result changed")
   `B2N_ASSERT_IMPL(a_ready_when_empty, clock, reset, !rsp_valid, req_ready, "not ready with empty output")
   `B2N_ASSERT_NEXT(a_check_enters, clock, reset, accept && req_func == b2nc_pkg::FUNC_CHECK, valid_s[1], "check transfer lost at entry")

endmodule
